/* rtl/bsfp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and the base-32 digit decoder of the sensor frame parser.
// No dependencies; every other file in this block imports it.
package bsfp_pkg;

  // Characters the parser reacts to
  localparam logic [7:0] CH_START = 8'h53;  // 'S'
  localparam logic [7:0] CH_END   = 8'h45;  // 'E'
  localparam logic [7:0] CH_SEQ   = 8'h59;  // 'Y'
  localparam logic [7:0] CH_IDLE  = 8'h4E;  // 'N'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_LOW_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOW_V = 8'h76;  // 'v'
  localparam logic [7:0] LETTER_BASE = 8'd10;

  localparam int DIGIT_W = 5;

  // Frame position codes: hunting, digit slots, waiting for the end mark
  localparam logic [3:0] POS_HUNT       = 4'd0;
  localparam logic [3:0] POS_TIME_FIRST = 4'd1;
  localparam logic [3:0] POS_FORCE_FIRST = 4'd8;
  localparam logic [3:0] POS_SIGNAL     = 4'd11;
  localparam logic [3:0] POS_FREQ_FIRST = 4'd12;
  localparam logic [3:0] POS_END        = 4'd15;

  localparam int TIME_DIGITS  = 7;
  localparam int FORCE_DIGITS = 3;
  localparam int FREQ_DIGITS  = 3;

  typedef enum logic [1:0] {
    EV_DATA = 2'd0,
    EV_SEQ  = 2'd1,
    EV_IDLE = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [34:0] time_value;
    logic [14:0] force_value;
    logic [4:0]  signal_flag;
    logic [14:0] frequency_value;
    logic [15:0] sequence_number;
    logic        bad_digit;
    logic [15:0] discard_total;
  } rec_t;

  typedef struct packed {
    logic                 ok;
    logic [DIGIT_W-1:0]   value;
  } digit_t;

  // Map '0'-'9' and 'a'-'v' to 0..31; anything else decodes as 0, not ok
  function automatic digit_t digit_decode(logic [7:0] c);
    digit_t d;
    d.ok    = 1'b0;
    d.value = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.ok    = 1'b1;
      d.value = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LOW_A && c <= CH_LOW_V) begin
      d.ok    = 1'b1;
      d.value = DIGIT_W'(c - CH_LOW_A + LETTER_BASE);
    end
    return d;
  endfunction

endpackage

/* rtl/base32_sensor_frame_parser.sv */
`timescale 1ns / 1ps
// Top level of the base-32 sensor frame parser: input register, frame core, output buffer.
// Depends on bsfp_pkg, bsfp_frame_core and bsfp_out_buf.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------------------------
//   in      | in_valid  | in_stall  | rx_byte
//   out     | out_valid | out_stall | event_kind, time_value, force_value, signal_flag,
//           |           |           | frequency_value, sequence_number, bad_digit,
//           |           |           | discard_total
//
// One byte per cycle sustained while in_stall is low; a beat waits in the input register
// and its record (if any) is registered into the output register or the skid stage.
// Reset (rst, synchronous) returns the parser to hunting with all counters at zero.
// in_stall rises only when the input register holds a byte and the output skid
// stage is full; it comes from registers, never straight from out_stall.
module base32_sensor_frame_parser import bsfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [34:0] time_value,
  output logic [14:0] force_value,
  output logic [4:0]  signal_flag,
  output logic [14:0] frequency_value,
  output logic [15:0] sequence_number,
  output logic        bad_digit,
  output logic [15:0] discard_total
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       buf_ready;
  logic       advance;
  logic       accept;
  logic       rec_valid;
  rec_t       rec;
  rec_t       out_rec;

  // Advance the held byte whenever the output buffer can take a record
  assign advance  = hold_valid && buf_ready;
  assign in_stall = hold_valid && !buf_ready;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= rx_byte;
    end
  end

  bsfp_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (hold_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  bsfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_valid),
    .push_rec  (rec),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (out_rec)
  );

  // Unpack the record onto the field ports
  assign event_kind      = out_rec.kind;
  assign time_value      = out_rec.time_value;
  assign force_value     = out_rec.force_value;
  assign signal_flag     = out_rec.signal_flag;
  assign frequency_value = out_rec.frequency_value;
  assign sequence_number = out_rec.sequence_number;
  assign bad_digit       = out_rec.bad_digit;
  assign discard_total   = out_rec.discard_total;

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && !buf_ready)
    else $error("input stalled with room to advance");

  a_events_carry_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_DATA |-> time_value == '0 && bad_digit == 1'b0)
    else $error("event record carries frame data");

  a_held_byte_moves: assert property (@(posedge clk) disable iff (rst)
    advance && !accept |=> !hold_valid)
    else $error("advanced byte still marked held");

endmodule

/* rtl/bsfp_frame_core.sv */
`timescale 1ns / 1ps
// Frame state and digit accumulators; turns one byte into at most one record.
// Depends on bsfp_pkg.
module bsfp_frame_core import bsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       rec_valid,
  output rec_t       rec
);

  logic [3:0]  pos, pos_next;
  logic [34:0] time_acc, time_acc_next;
  logic [14:0] force_acc, force_acc_next;
  logic [4:0]  signal_acc, signal_acc_next;
  logic [14:0] freq_acc, freq_acc_next;
  logic        bad_seen, bad_seen_next;
  logic [15:0] seq_cnt, seq_cnt_next;
  logic [15:0] disc_cnt, disc_cnt_next;
  logic        emit;
  rec_t        rec_c;
  digit_t      dig;

  always_comb begin
    pos_next        = pos;
    time_acc_next   = time_acc;
    force_acc_next  = force_acc;
    signal_acc_next = signal_acc;
    freq_acc_next   = freq_acc;
    bad_seen_next   = bad_seen;
    seq_cnt_next    = seq_cnt;
    disc_cnt_next   = disc_cnt;
    emit            = 1'b0;
    dig             = digit_decode(rx_byte);
    rec_c           = '0;
    rec_c.kind      = EV_DATA;

    if (pos == POS_HUNT) begin
      priority if (rx_byte == CH_START) begin
        time_acc_next   = '0;
        force_acc_next  = '0;
        signal_acc_next = '0;
        freq_acc_next   = '0;
        bad_seen_next   = 1'b0;
        pos_next        = POS_TIME_FIRST;
      end else if (rx_byte == CH_SEQ) begin
        seq_cnt_next = seq_cnt + 16'd1;
        emit         = 1'b1;
        rec_c.kind   = EV_SEQ;
      end else if (rx_byte == CH_IDLE) begin
        emit       = 1'b1;
        rec_c.kind = EV_IDLE;
      end else begin
        // Count the byte as a discard; hold at the top value
        if (disc_cnt != '1) begin
          disc_cnt_next = disc_cnt + 16'd1;
        end
      end
    end else if (pos == POS_END) begin
      // A wrong end mark drops this byte silently
      pos_next = POS_HUNT;
      if (rx_byte == CH_END) begin
        emit                  = 1'b1;
        rec_c.time_value      = time_acc;
        rec_c.force_value     = force_acc;
        rec_c.signal_flag     = signal_acc;
        rec_c.frequency_value = freq_acc;
        rec_c.bad_digit       = bad_seen;
      end
    end else begin
      if (!dig.ok) begin
        bad_seen_next = 1'b1;
      end
      for (int k = 0; k < TIME_DIGITS; k++) begin
        if (pos == 4'(POS_TIME_FIRST + k)) begin
          time_acc_next[DIGIT_W*k +: DIGIT_W] = time_acc[DIGIT_W*k +: DIGIT_W] | dig.value;
        end
      end
      for (int k = 0; k < FORCE_DIGITS; k++) begin
        if (pos == 4'(POS_FORCE_FIRST + k)) begin
          force_acc_next[DIGIT_W*k +: DIGIT_W] = force_acc[DIGIT_W*k +: DIGIT_W] | dig.value;
        end
      end
      if (pos == POS_SIGNAL) begin
        signal_acc_next = dig.value;
      end
      for (int k = 0; k < FREQ_DIGITS; k++) begin
        if (pos == 4'(POS_FREQ_FIRST + k)) begin
          freq_acc_next[DIGIT_W*k +: DIGIT_W] = freq_acc[DIGIT_W*k +: DIGIT_W] | dig.value;
        end
      end
      pos_next = pos + 4'd1;
    end

    // Counters as they stand after this byte
    rec_c.sequence_number = seq_cnt_next;
    rec_c.discard_total   = disc_cnt_next;
  end

  assign rec_valid = step && emit;
  assign rec       = rec_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_HUNT;
      time_acc   <= '0;
      force_acc  <= '0;
      signal_acc <= '0;
      freq_acc   <= '0;
      bad_seen   <= 1'b0;
      seq_cnt    <= '0;
      disc_cnt   <= '0;
    end else if (step) begin
      pos        <= pos_next;
      time_acc   <= time_acc_next;
      force_acc  <= force_acc_next;
      signal_acc <= signal_acc_next;
      freq_acc   <= freq_acc_next;
      bad_seen   <= bad_seen_next;
      seq_cnt    <= seq_cnt_next;
      disc_cnt   <= disc_cnt_next;
    end
  end

  a_emit_at_frame_edge: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> (pos == POS_HUNT || pos == POS_END))
    else $error("record emitted in the middle of a frame");

  a_seq_only_on_y: assert property (@(posedge clk) disable iff (rst)
    !(step && pos == POS_HUNT && rx_byte == CH_SEQ) |=> $stable(seq_cnt))
    else $error("sequence count moved without a sequence change");

  a_discard_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> disc_cnt >= $past(disc_cnt))
    else $error("discard count went down");

endmodule

/* rtl/bsfp_out_buf.sv */
`timescale 1ns / 1ps
// Result register with a skid stage, so the core sees a registered ready.
// Depends on bsfp_pkg.
module bsfp_out_buf import bsfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic ready,
  output logic out_valid,
  input  logic out_stall,
  output rec_t out_rec
);

  logic skid_valid;
  rec_t skid_rec;
  logic pop;

  assign pop   = out_valid && !out_stall;
  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_rec <= skid_rec;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_rec <= push_rec;
      end else begin
        out_rec <= push_rec;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage filled while output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("beat pushed into full buffer");

endmodule

/* sim/bsfp_frame_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for base32_sensor_frame_parser: tracks both channels, predicts each record.
// Depends on bsfp_pkg for the character codes, slot layout and the record type.
module bsfp_frame_checker import bsfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  event_kind,
  input  logic [34:0] time_value,
  input  logic [14:0] force_value,
  input  logic [4:0]  signal_flag,
  input  logic [14:0] frequency_value,
  input  logic [15:0] sequence_number,
  input  logic        bad_digit,
  input  logic [15:0] discard_total,
  output int          mismatch_count,
  output int          pending_count,
  output int          data_seen,
  output int          event_seen
);

  // Parser state as the checker sees it
  logic [3:0]  frame_slot;
  logic [34:0] stamp_acc;
  logic [14:0] level_acc;
  logic [4:0]  flag_acc;
  logic [14:0] rate_acc;
  logic        saw_bad_char;
  logic [15:0] seq_count;
  logic [15:0] discards;

  rec_t pending_records[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    data_seen      = 0;
    event_seen     = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void queue_record(input event_kind_t kind);
    rec_t r;
    r = '0;
    r.kind = kind;
    if (kind == EV_DATA) begin
      r.time_value      = stamp_acc;
      r.force_value     = level_acc;
      r.signal_flag     = flag_acc;
      r.frequency_value = rate_acc;
      r.bad_digit       = saw_bad_char;
    end
    r.sequence_number = seq_count;
    r.discard_total   = discards;
    pending_records.insert(pending_records.size(), r);
  endfunction

  // Advance the frame hunt by one received byte; queue the record it causes, if any
  function automatic void parse_byte(input logic [7:0] c);
    logic [4:0] d;
    logic       ok;
    int         idx;
    if (frame_slot == POS_HUNT) begin
      if (c == CH_START) begin
        stamp_acc    = '0;
        level_acc    = '0;
        flag_acc     = '0;
        rate_acc     = '0;
        saw_bad_char = 1'b0;
        frame_slot   = POS_TIME_FIRST;
      end else if (c == CH_SEQ) begin
        seq_count = seq_count + 16'd1;
        queue_record(EV_SEQ);
      end else if (c == CH_IDLE) begin
        queue_record(EV_IDLE);
      end else if (discards != 16'hFFFF) begin
        discards = discards + 16'd1;
      end
    end else if (frame_slot == POS_END) begin
      // a wrong end mark just drops the byte, no discard count
      frame_slot = POS_HUNT;
      if (c == CH_END)
        queue_record(EV_DATA);
    end else begin
      ok = 1'b1;
      d  = '0;
      if (c >= CH_ZERO && c <= CH_NINE)
        d = 5'(c - CH_ZERO);
      else if (c >= CH_LOW_A && c <= CH_LOW_V)
        d = 5'(c - CH_LOW_A + 8'd10);
      else
        ok = 1'b0;
      if (!ok)
        saw_bad_char = 1'b1;
      idx = int'(frame_slot) - 1;
      if (idx < TIME_DIGITS)
        stamp_acc[5*idx +: 5] = d;
      else if (idx < TIME_DIGITS + FORCE_DIGITS)
        level_acc[5*(idx-TIME_DIGITS) +: 5] = d;
      else if (idx == TIME_DIGITS + FORCE_DIGITS)
        flag_acc = d;
      else
        rate_acc[5*(idx-TIME_DIGITS-FORCE_DIGITS-1) +: 5] = d;
      frame_slot = frame_slot + 4'd1;
    end
  endfunction

  always @(posedge clk) begin
    rec_t want;
    if (rst) begin
      frame_slot   = POS_HUNT;
      stamp_acc    = '0;
      level_acc    = '0;
      flag_acc     = '0;
      rate_acc     = '0;
      saw_bad_char = 1'b0;
      seq_count    = '0;
      discards     = '0;
      pending_records.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_records.size() == 0) begin
          report_mismatch("record beat with nothing expected");
        end else begin
          want = pending_records.pop_front();
          if (want.kind == EV_DATA) data_seen <= data_seen + 1;
          else event_seen <= event_seen + 1;
          if (event_kind !== want.kind)
            report_mismatch($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
          if (time_value !== want.time_value)
            report_mismatch($sformatf("time_value %0h, want %0h",
                                      time_value, want.time_value));
          if (force_value !== want.force_value)
            report_mismatch($sformatf("force_value %0h, want %0h",
                                      force_value, want.force_value));
          if (signal_flag !== want.signal_flag)
            report_mismatch($sformatf("signal_flag %0h, want %0h",
                                      signal_flag, want.signal_flag));
          if (frequency_value !== want.frequency_value)
            report_mismatch($sformatf("frequency_value %0h, want %0h",
                                      frequency_value, want.frequency_value));
          if (sequence_number !== want.sequence_number)
            report_mismatch($sformatf("sequence_number %0d, want %0d",
                                      sequence_number, want.sequence_number));
          if (bad_digit !== want.bad_digit)
            report_mismatch($sformatf("bad_digit %0b, want %0b", bad_digit, want.bad_digit));
          if (discard_total !== want.discard_total)
            report_mismatch($sformatf("discard_total %0d, want %0d",
                                      discard_total, want.discard_total));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        parse_byte(rx_byte);
    end
    pending_count <= pending_records.size();
  end

endmodule

/* sim/tb_base32_sensor_frame_parser.sv */
`timescale 1ns / 1ps
// Top of the parser testbench: clock, reset, byte stimulus, receiver back-pressure, verdict.
// Depends on bsfp_pkg, base32_sensor_frame_parser and bsfp_frame_checker.
module tb_base32_sensor_frame_parser;
  import bsfp_pkg::*;

  localparam int DIRECTED_BYTES = 20;
  localparam int RANDOM_BYTES   = 950;
  localparam int HOLD_AT        = DIRECTED_BYTES + 300;  // bytes sent before the long hold
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 10;   // byte register plus output register, with margin
  localparam int TAIL_ITEMS     = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [34:0] time_value;
  logic [14:0] force_value;
  logic [4:0]  signal_flag;
  logic [14:0] frequency_value;
  logic [15:0] sequence_number;
  logic        bad_digit;
  logic [15:0] discard_total;

  int mismatch_count;
  int pending_count;
  int data_seen;
  int event_seen;

  int bytes_sent   = 0;
  int input_stalls = 0;
  int calm_left    = 0;    // bytes still to send back to back
  bit quiet        = 1'b0; // set for the last part: no idling on either side
  bit hold_done    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  base32_sensor_frame_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .time_value(time_value), .force_value(force_value),
    .signal_flag(signal_flag), .frequency_value(frequency_value),
    .sequence_number(sequence_number), .bad_digit(bad_digit),
    .discard_total(discard_total)
  );

  bsfp_frame_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .time_value(time_value), .force_value(force_value),
    .signal_flag(signal_flag), .frequency_value(frequency_value),
    .sequence_number(sequence_number), .bad_digit(bad_digit),
    .discard_total(discard_total),
    .mismatch_count(mismatch_count), .pending_count(pending_count),
    .data_seen(data_seen), .event_seen(event_seen)
  );

  // Track how often the parser pushed back on the byte stream
  always @(posedge clk)
    if (in_valid && in_stall) input_stalls <= input_stalls + 1;

  // Offer one byte and hold it until the parser takes the beat.
  // Before it, sometimes drop valid for a burst of random length.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet) begin
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 40) == 0) begin
        calm_left = $urandom_range(20, 60);
      end else if ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
    rx_byte  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] digit_char(input int v);
    return (v < 10) ? 8'(CH_ZERO + v) : 8'(CH_LOW_A + v - 10);
  endfunction

  // Start mark, fourteen digits, end mark. One in bad_odds+1 digits is a raw byte
  // (usually outside the alphabet); a broken frame ends with a random byte instead.
  task automatic send_frame(input bit broken_end, input int bad_odds);
    send_byte(CH_START);
    repeat (14) begin
      if ($urandom_range(0, bad_odds) == 0)
        send_byte(8'($urandom_range(0, 255)));
      else
        send_byte(digit_char($urandom_range(0, 31)));
    end
    send_byte(broken_end ? 8'($urandom_range(0, 255)) : CH_END);
  endtask

  // Half well-formed frames with random content, the rest commands, noise and broken frames
  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      send_frame(1'b0, ($urandom_range(0, 3) == 0) ? 6 : 100000);
    else if (pick < 60)
      send_frame(1'b1, 20);
    else if (pick < 70)
      send_byte(CH_SEQ);
    else if (pick < 80)
      send_byte(CH_IDLE);
    else
      send_byte(8'($urandom_range(0, 255)));
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold that
  // lets the parser fill up and push back on the byte stream
  initial begin : receiver
    int r;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet) begin
        r = $urandom_range(0, 15);
        if (r < 3) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 13)) @(posedge clk);
          out_stall <= 1'b0;
        end else if (r == 3) begin
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a frame of all top digits, both commands, both byte extremes as discards
    send_byte(CH_START);
    repeat (14) send_byte(CH_LOW_V);
    send_byte(CH_END);
    send_byte(CH_SEQ);
    send_byte(CH_IDLE);
    send_byte(8'h00);
    send_byte(8'hFF);

    while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES)
      send_random_item();

    // Last part, no idling on either side
    quiet = 1'b1;
    repeat (TAIL_ITEMS) send_random_item();
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes, %0d input stall cycles, %0d data records and %0d events",
             bytes_sent, input_stalls, data_seen, event_seen);
    $display("frames with bad digits and broken end marks, commands, noise and a long hold");
    if (mismatch_count == 0 && pending_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("watchdog expired with %0d records outstanding", pending_count);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/bsfp_pkg.sv
rtl/bsfp_frame_core.sv
rtl/bsfp_out_buf.sv
rtl/base32_sensor_frame_parser.sv
sim/bsfp_frame_checker.sv
sim/tb_base32_sensor_frame_parser.sv
